FILE: rtl/core/rlfe_pkg.sv
package rlfe_pkg;

	localparam int COLOR_W    = 8;
	localparam int DUR_IN_W   = 16;
	localparam int CFG_W      = 16;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_W-1:0] POWER_TIME_RESET = 16'd1000;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_MOVE  = 2'd2,
		KIND_POWER = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_WRITE
	} state_t;

	typedef logic [1:0] chan_t;
	localparam chan_t CHAN_FIRST = 2'd0;
	localparam chan_t CHAN_LAST  = 2'd2;

	typedef struct packed {
		logic  load_item;
		logic  exec;
		logic  div_start;
		logic  store_step;
		logic  fade_on;
		logic  load_out;
		chan_t chan;
	} cmd_t;

	typedef struct packed {
		logic fade_kind;
		logic dur_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/rlfe_div.sv
module rlfe_div #(
	parameter int N_W = 24,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0]   shifted;
	logic [D_W:0]   diff;
	logic           ge;
	logic [D_W-1:0] rem_nx;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = (shifted >= {1'b0, div_q});
		rem_nx  = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/rlfe_datapath.sv
module rlfe_datapath #(
	parameter int FRAC_BITS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlfe_pkg::cmd_t                  cmd,
	output rlfe_pkg::status_t               status,
	input  logic [rlfe_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [rlfe_pkg::KIND_W-1:0]     s_tuser,
	input  logic                            cfg_valid,
	input  logic [rlfe_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [rlfe_pkg::OUT_DATA_W-1:0] m_tdata
);

	import rlfe_pkg::*;

	localparam int LW    = COLOR_W + FRAC_BITS;
	localparam int SW    = LW + 1;
	localparam int DIV_W = (DURATION_BITS < DUR_IN_W) ? DURATION_BITS : DUR_IN_W;

	localparam logic [LW-1:0]        LEVEL_MAX = '1;
	localparam logic signed [SW-1:0] ONE_UNIT  = SW'(64'd1 << FRAC_BITS);
	localparam logic [DUR_IN_W-1:0]  DUR_LIMIT = DUR_IN_W'((64'd1 << DIV_W) - 64'd1);

	kind_t                kind_q;
	logic [COLOR_W-1:0]   col_q    [3];
	logic [DIV_W-1:0]     dur_q;
	logic [CFG_W-1:0]     power_time_q;
	logic [LW-1:0]        level_q  [3];
	logic [COLOR_W-1:0]   target_q [3];
	logic signed [SW-1:0] step_q   [3];
	logic                 in_fade_q;
	logic                 sign_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	kind_t                in_kind;
	logic [DUR_IN_W-1:0]  dur_raw;
	logic [DUR_IN_W-1:0]  dur_sat;
	logic                 any_nz;
	logic [COLOR_W-1:0]   power_goal;
	logic [COLOR_W-1:0]   goal      [3];
	logic [LW+1:0]        sum       [3];
	logic [LW-1:0]        clamped   [3];
	logic signed [SW-1:0] delta     [3];
	logic                 near      [3];
	logic [LW-1:0]        tick_level[3];
	logic signed [SW-1:0] tick_step [3];
	logic                 tick_fade;
	logic signed [SW-1:0] num;
	logic signed [SW-1:0] num_mag;
	logic [LW-1:0]        dividend;
	logic                 div_done;
	logic [LW-1:0]        quotient;
	logic signed [SW-1:0] step_res;

	always_comb begin
		in_kind = kind_t'(s_tuser);
		dur_raw = (in_kind == KIND_POWER) ? power_time_q : s_tdata[IN_DATA_W-1 -: DUR_IN_W];
		dur_sat = (dur_raw > DUR_LIMIT) ? DUR_LIMIT : dur_raw;
	end

	always_comb begin
		any_nz     = (level_q[0] != '0) || (level_q[1] != '0) || (level_q[2] != '0);
		power_goal = any_nz ? '0 : '1;
		for (int c = 0; c < 3; c++) begin
			goal[c] = (kind_q == KIND_POWER) ? power_goal : col_q[c];
		end
	end

	// tick: add step, saturate, snap when within one unit of target
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = {2'b00, level_q[c]} + {step_q[c][SW-1], step_q[c]};
			if (sum[c][LW+1]) begin
				clamped[c] = '0;
			end else if (sum[c][LW]) begin
				clamped[c] = LEVEL_MAX;
			end else begin
				clamped[c] = sum[c][LW-1:0];
			end
			delta[c] = $signed({1'b0, clamped[c]}) -
			           $signed({1'b0, target_q[c], {FRAC_BITS{1'b0}}});
			near[c] = (delta[c] < ONE_UNIT) && (delta[c] > -ONE_UNIT);
			tick_level[c] = near[c] ? {target_q[c], {FRAC_BITS{1'b0}}} : clamped[c];
			tick_step[c]  = near[c] ? '0 : step_q[c];
		end
		tick_fade = (tick_step[0] != '0) || (tick_step[1] != '0) || (tick_step[2] != '0);
	end

	always_comb begin
		num      = $signed({1'b0, target_q[cmd.chan], {FRAC_BITS{1'b0}}}) -
		           $signed({1'b0, level_q[cmd.chan]});
		num_mag  = num[SW-1] ? -num : num;
		dividend = num_mag[LW-1:0];
		step_res = sign_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
	end

	rlfe_div #(
		.N_W (LW),
		.D_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (dur_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_time_q <= POWER_TIME_RESET;
			in_fade_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				level_q[c]  <= '0;
				target_q[c] <= '0;
				step_q[c]   <= '0;
			end
		end else begin
			if (cfg_valid) begin
				power_time_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (kind_q)
					KIND_TICK: begin
						if (in_fade_q) begin
							for (int c = 0; c < 3; c++) begin
								level_q[c] <= tick_level[c];
								step_q[c]  <= tick_step[c];
							end
							in_fade_q <= tick_fade;
						end
					end
					KIND_SET: begin
						for (int c = 0; c < 3; c++) begin
							level_q[c] <= {col_q[c], {FRAC_BITS{1'b0}}};
						end
					end
					KIND_MOVE, KIND_POWER: begin
						for (int c = 0; c < 3; c++) begin
							target_q[c] <= goal[c];
						end
						if (dur_q == '0) begin
							for (int c = 0; c < 3; c++) begin
								level_q[c] <= {goal[c], {FRAC_BITS{1'b0}}};
								step_q[c]  <= '0;
							end
							in_fade_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.store_step) begin
				step_q[cmd.chan] <= step_res;
			end
			if (cmd.fade_on) begin
				in_fade_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= in_kind;
			dur_q  <= dur_sat[DIV_W-1:0];
			for (int c = 0; c < 3; c++) begin
				col_q[c] <= s_tdata[c*COLOR_W +: COLOR_W];
			end
		end
		if (cmd.div_start) begin
			sign_q <= num[SW-1];
		end
		if (cmd.load_out) begin
			out_data_q <= {4'b0000, in_fade_q,
			               (level_q[2] != '0), (level_q[1] != '0), (level_q[0] != '0),
			               level_q[2][LW-1 -: COLOR_W], level_q[1][LW-1 -: COLOR_W],
			               level_q[0][LW-1 -: COLOR_W]};
		end
	end

	always_comb begin
		status.fade_kind = kind_q inside {KIND_MOVE, KIND_POWER};
		status.dur_zero  = (dur_q == '0);
		status.div_done  = div_done;
		status.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/core/rlfe_ctrl.sv
module rlfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rlfe_pkg::status_t status,
	output rlfe_pkg::cmd_t    cmd
);

	import rlfe_pkg::*;

	state_t state_q;
	state_t state_nx;
	chan_t  chan_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.fade_kind && !status.dur_zero) begin
					state_nx = ST_DIV_START;
				end else begin
					state_nx = ST_WRITE;
				end
			end
			ST_DIV_START: begin
				state_nx = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (status.div_done) begin
					state_nx = (chan_q == CHAN_LAST) ? ST_WRITE : ST_DIV_START;
				end
			end
			ST_WRITE: begin
				if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.chan       = chan_q;
		case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV_RUN: begin
				cmd.store_step = status.div_done;
				cmd.fade_on    = status.div_done && (chan_q == CHAN_LAST);
			end
			ST_WRITE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= CHAN_FIRST;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_EXEC) begin
				chan_q <= CHAN_FIRST;
			end else if (state_q == ST_DIV_RUN && status.div_done && chan_q != CHAN_LAST) begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/rgb_linear_fade_engine_unit.sv
// Tick, set and zero-duration items go from the input transfer through EXEC to WRITE, where the
// result register is loaded once it is free. Move and power items with nonzero duration run
// three passes of the one-bit-per-cycle divider between EXEC and WRITE, one per channel.
// One item in flight; the next transfer is taken once the result register is loaded.
// Reset: arst_n clears levels, targets, steps and fade mode at once; power_time resets to 1000.
module rgb_linear_fade_engine_unit #(
	parameter int FRAC_BITS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// red[7:0], green[15:8], blue[23:16], duration_ms[39:24]
	input  logic [rlfe_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [rlfe_pkg::KIND_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty_red[7:0], duty_green[15:8], duty_blue[23:16], enable_red[24],
	// enable_green[25], enable_blue[26], fading[27], zero[31:28]
	output logic [rlfe_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	// power_time[15:0]
	input  logic [rlfe_pkg::CFG_W-1:0]      cfg_data
);

	import rlfe_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	rlfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rlfe_datapath #(
		.FRAC_BITS     (FRAC_BITS),
		.DURATION_BITS (DURATION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input transfer taken while an item is in flight");

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before its transfer");

	a_step_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_step |-> status.div_done)
		else $error("step stored without a finished division");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rlfe_pkg::*;

	localparam int      FRAC       = 16;
	localparam longint  LEVEL_TOP  = 64'h00FF_FFFF;
	localparam longint  ONE_UNIT   = 64'h0001_0000;
	localparam int      QUIET_MAX  = 4000;
	localparam int      PHASE_ITEMS = 250;

	// duty_red, duty_green, duty_blue, enables, fading, from bit 0 up
	typedef struct packed {
		logic [3:0] pad;
		logic       fading;
		logic       en_b;
		logic       en_g;
		logic       en_r;
		logic [7:0] duty_b;
		logic [7:0] duty_g;
		logic [7:0] duty_r;
	} fade_out_t;

	typedef struct {
		kind_t            kind;
		logic [IN_DATA_W-1:0] data;
		bit               fixed;
		fade_out_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	rgb_linear_fade_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// fader shadow state
	logic [23:0]        lvl [3];
	logic [7:0]         tgt [3];
	logic signed [24:0] stp [3];
	bit                 fade_on;
	logic [CFG_W-1:0]   power_time_m = POWER_TIME_RESET;

	fade_out_t pending_duty [$];
	stim_row_t stim_rows [$];
	int        errors = 0;
	int        items_sent = 0;
	int        quiet = 0;
	int        stall_left = 0;
	bit        calm = 1'b0;
	fade_out_t got, want;

	initial begin
		for (int c = 0; c < 3; c++) begin
			lvl[c] = '0;
			tgt[c] = '0;
			stp[c] = '0;
		end
		fade_on = 1'b0;
	end

	function automatic void launch_fade(input logic [2:0][7:0] goal, input logic [15:0] dur);
		longint num;
		for (int c = 0; c < 3; c++) begin
			tgt[c] = goal[c];
			if (dur == 0) begin
				lvl[c] = {goal[c], 16'h0};
				stp[c] = '0;
			end else begin
				num = longint'({goal[c], 16'h0}) - longint'(lvl[c]);
				stp[c] = 25'(num / longint'(dur));
			end
		end
		fade_on = (dur != 0);
	endfunction

	function automatic void tick_fader();
		longint v, d;
		if (fade_on) begin
			for (int c = 0; c < 3; c++) begin
				v = longint'(lvl[c]) + longint'(stp[c]);
				if (v < 0)
					v = 0;
				if (v > LEVEL_TOP)
					v = LEVEL_TOP;
				d = v - longint'({tgt[c], 16'h0});
				if (d < 0)
					d = -d;
				// close enough: snap and stop this channel
				if (d < ONE_UNIT) begin
					v = longint'({tgt[c], 16'h0});
					stp[c] = '0;
				end
				lvl[c] = v[23:0];
			end
			if (stp[0] == 0 && stp[1] == 0 && stp[2] == 0)
				fade_on = 1'b0;
		end
	endfunction

	function automatic fade_out_t advance_fader(input kind_t k, input logic [IN_DATA_W-1:0] d);
		logic [2:0][7:0] col;
		logic [7:0]      g;
		fade_out_t       o;
		col = d[23:0];
		case (k)
			KIND_TICK: tick_fader();
			KIND_SET: begin
				for (int c = 0; c < 3; c++)
					lvl[c] = {col[c], 16'h0};
			end
			KIND_MOVE: launch_fade(col, d[39:24]);
			default: begin
				g = (lvl[0] != 0 || lvl[1] != 0 || lvl[2] != 0) ? 8'h00 : 8'hFF;
				launch_fade({g, g, g}, power_time_m);
			end
		endcase
		o = '0;
		o.duty_r = lvl[0][23:FRAC];
		o.duty_g = lvl[1][23:FRAC];
		o.duty_b = lvl[2][23:FRAC];
		o.en_r   = (lvl[0] != 0);
		o.en_g   = (lvl[1] != 0);
		o.en_b   = (lvl[2] != 0);
		o.fading = fade_on;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_color();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'h00;
		else if (r < 30)
			return 8'hFF;
		else
			return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'd0;
		else if (r < 75)
			return 16'($urandom_range(1, 12));
		else if (r < 90)
			return 16'($urandom_range(13, 300));
		else
			return 16'($urandom);
	endfunction

	function automatic logic [IN_DATA_W-1:0] rand_payload();
		return {8'($urandom), 32'($urandom)};
	endfunction

	function automatic void check_field(input string name, input int unsigned w, input int unsigned a);
		if (w != a) begin
			$error("%s mismatch: expected %0h, got %0h", name, w, a);
			errors++;
		end
	endfunction

	task automatic push_item(input kind_t k, input logic [IN_DATA_W-1:0] d,
			input bit fixed, input fade_out_t fixed_want);
		int gap;
		fade_out_t pred;
		gap = calm ? 0 : pick_gap();
		// valid stays high from the previous transfer when there is no gap
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		pred = advance_fader(k, d);
		pending_duty.push_back(fixed ? fixed_want : pred);
		items_sent++;
	endtask

	task automatic add_row(input kind_t k, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [15:0] dur, input bit fixed, input fade_out_t w);
		stim_row_t row;
		row.kind  = k;
		row.data  = {dur, b, g, r};
		row.fixed = fixed;
		row.want  = w;
		stim_rows.push_back(row);
	endtask

	task automatic write_power_time(input logic [CFG_W-1:0] v);
		while (pending_duty.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		power_time_m = v;
	endtask

	task automatic run_random(input int quota);
		int stop_at, r, n;
		logic [15:0] dur;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				// move followed by enough ticks to finish most fades
				dur = pick_duration();
				push_item(KIND_MOVE, {dur, pick_color(), pick_color(), pick_color()}, 1'b0, '0);
				n = (dur > 30 ? 30 : int'(dur)) + $urandom_range(0, 3);
				repeat (n) begin
					if ($urandom_range(0, 24) == 0)
						push_item(KIND_SET, {16'($urandom), pick_color(), pick_color(),
							pick_color()}, 1'b0, '0);
					else
						push_item(KIND_TICK, rand_payload(), 1'b0, '0);
				end
			end else if (r < 78) begin
				push_item(KIND_POWER, rand_payload(), 1'b0, '0);
				n = (power_time_m > 30 ? 30 : int'(power_time_m)) + $urandom_range(0, 2);
				repeat (n) push_item(KIND_TICK, rand_payload(), 1'b0, '0);
			end else if (r < 90) begin
				push_item(KIND_SET, {16'($urandom), pick_color(), pick_color(), pick_color()},
					1'b0, '0);
			end else begin
				push_item(kind_t'($urandom_range(0, 3)), rand_payload(), 1'b0, '0);
			end
		end
	endtask

	// result side: random stalls, with calm stretches of none
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			calm <= ~calm;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = fade_out_t'(m_tdata);
			if (pending_duty.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = pending_duty.pop_front();
				check_field("duty_red", want.duty_r, got.duty_r);
				check_field("duty_green", want.duty_g, got.duty_g);
				check_field("duty_blue", want.duty_b, got.duty_b);
				check_field("enable_red", want.en_r, got.en_r);
				check_field("enable_green", want.en_g, got.en_g);
				check_field("enable_blue", want.en_b, got.en_b);
				check_field("fading", want.fading, got.fading);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, fade_out_t'(32'h0000_0000));
		add_row(KIND_SET, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, fade_out_t'(32'h07FF_FFFF));
		add_row(KIND_SET, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, fade_out_t'(32'h0000_0000));
		add_row(KIND_MOVE, 8'hFF, 8'h00, 8'h80, 16'h0000, 1'b1, fade_out_t'(32'h0580_00FF));
		add_row(KIND_MOVE, 8'h00, 8'hFF, 8'h00, 16'h0003, 1'b0, '0);
		repeat (4) add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_row(KIND_SET, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, fade_out_t'(32'h0000_0000));
		// set during a fade, next tick saturates high and the fade runs on
		add_row(KIND_MOVE, 8'h80, 8'h80, 8'h80, 16'h0002, 1'b0, '0);
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_row(KIND_SET, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0, '0);
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		// and the same downward, saturating at zero
		add_row(KIND_MOVE, 8'h80, 8'h80, 8'h80, 16'h0002, 1'b0, '0);
		add_row(KIND_SET, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		// fractional level, then a step that truncates to zero
		add_row(KIND_MOVE, 8'h01, 8'h00, 8'h00, 16'h0003, 1'b0, '0);
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_row(KIND_MOVE, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, '0);
		add_row(KIND_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		// power from black goes to white, from lit goes to black
		add_row(KIND_POWER, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, '0);
		add_row(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, '0);
		add_row(KIND_POWER, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_row(KIND_MOVE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			push_item(stim_rows[i].kind, stim_rows[i].data, stim_rows[i].fixed,
				stim_rows[i].want);
		run_random(PHASE_ITEMS);

		for (int p = 1; p <= 5; p++) begin
			s_tvalid <= 1'b0;
			case (p)
				1: write_power_time(16'h0000);
				2: write_power_time(16'hFFFF);
				3: write_power_time(16'h0001);
				4: write_power_time(16'($urandom_range(2, 40)));
				default: write_power_time(16'h0005);
			endcase
			run_random(PHASE_ITEMS);
		end

		s_tvalid <= 1'b0;
		while (pending_duty.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
